// File: hdl/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, constants and helpers for the NEC IR frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

    typedef enum logic [2:0] {
        SYM_ZERO   = 3'd0,
        SYM_ONE    = 3'd1,
        SYM_HEADER = 3'd2,
        SYM_STOP   = 3'd3,
        SYM_NONE   = 3'd4
    } necir_sym_t;

    typedef enum logic [2:0] {
        REG_BIT_MARK    = 3'd0,
        REG_ZERO_SPACE  = 3'd1,
        REG_ONE_SPACE   = 3'd2,
        REG_HDR_MARK    = 3'd3,
        REG_HDR_SPACE   = 3'd4,
        REG_BIT_TOL     = 3'd5,
        REG_HDR_TOL     = 3'd6,
        REG_STOP_TOL    = 3'd7
    } necir_reg_t;

    typedef struct packed {
        logic [15:0] bit_mark_us;
        logic [15:0] zero_space_us;
        logic [15:0] one_space_us;
        logic [15:0] header_mark_us;
        logic [15:0] header_space_us;
        logic [15:0] bit_tolerance_us;
        logic [15:0] header_tolerance_us;
        logic [15:0] stop_tolerance_us;
    } necir_cfg_t;

    localparam logic [15:0] BIT_MARK_RST   = 16'd600;
    localparam logic [15:0] ZERO_SPACE_RST = 16'd600;
    localparam logic [15:0] ONE_SPACE_RST  = 16'd1600;
    localparam logic [15:0] HDR_MARK_RST   = 16'd9000;
    localparam logic [15:0] HDR_SPACE_RST  = 16'd4500;
    localparam logic [15:0] BIT_TOL_RST    = 16'd150;
    localparam logic [15:0] HDR_TOL_RST    = 16'd1500;
    localparam logic [15:0] STOP_TOL_RST   = 16'd150;

    localparam int DIGITS = 10;
    localparam logic [31:0] DIGIT_CODES [DIGITS] = '{
        32'hE916FF00, 32'hF30CFF00, 32'hE718FF00, 32'hA15EFF00, 32'hF708FF00,
        32'hE31CFF00, 32'hA55AFF00, 32'hBD42FF00, 32'hAD52FF00, 32'hB54AFF00
    };

    // |value - nominal| <= tol
    function automatic logic in_window(input logic [15:0] value, input logic [15:0] nominal,
                                       input logic [15:0] tol);
        logic [16:0] diff;
        logic [16:0] mag;
        begin
            diff = {1'b0, value} - {1'b0, nominal};
            mag  = diff[16] ? (17'd0 - diff) : diff;
            return mag <= {1'b0, tol};
        end
    endfunction

    // digit 0 is full brightness, digit k is k tenths, anything else is off
    function automatic logic [6:0] duty_for(input logic [31:0] code);
        logic [6:0] duty;
        begin
            duty = 7'd0;
            for (int k = 0; k < DIGITS; k++)
            begin
                if (code == DIGIT_CODES[k])
                    duty = (k == 0) ? 7'd100 : 7'(k * 10);
            end
            return duty;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/necir_classify.sv
// ----------------------------------------------------------------------------
// necir_classify
// Classifies a mark and the segment after it as zero, one, header or stop.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_classify (
    input  wire necir_pkg::necir_cfg_t cfg,
    input  wire logic [15:0]           mark_us,
    input  wire logic                  second_is_space,
    input  wire logic [15:0]           second_us,
    output necir_pkg::necir_sym_t      symbol
);

    logic mark_bit;
    logic mark_hdr;
    logic mark_stop;
    logic sp_zero;
    logic sp_one;
    logic sp_hdr;

    assign mark_bit  = necir_pkg::in_window(mark_us, cfg.bit_mark_us, cfg.bit_tolerance_us);
    assign mark_hdr  = necir_pkg::in_window(mark_us, cfg.header_mark_us,
                                            cfg.header_tolerance_us);
    assign mark_stop = necir_pkg::in_window(mark_us, cfg.bit_mark_us, cfg.stop_tolerance_us);
    assign sp_zero   = necir_pkg::in_window(second_us, cfg.zero_space_us,
                                            cfg.bit_tolerance_us);
    assign sp_one    = necir_pkg::in_window(second_us, cfg.one_space_us, cfg.bit_tolerance_us);
    assign sp_hdr    = necir_pkg::in_window(second_us, cfg.header_space_us,
                                            cfg.header_tolerance_us);

    // stop only needs the mark, so it also matches when the next segment is a mark
    always_comb
    begin
        priority if (second_is_space && mark_bit && sp_zero)
            symbol = necir_pkg::SYM_ZERO;
        else if (second_is_space && mark_bit && sp_one)
            symbol = necir_pkg::SYM_ONE;
        else if (second_is_space && mark_hdr && sp_hdr)
            symbol = necir_pkg::SYM_HEADER;
        else if (mark_stop)
            symbol = necir_pkg::SYM_STOP;
        else
            symbol = necir_pkg::SYM_NONE;
    end

endmodule

`default_nettype wire

// File: hdl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC IR frame decoder with a digit-key dimmed PWM LED output.
// ----------------------------------------------------------------------------
// Takes one item per clock while m_axis_tready stays high: an item is
// registered at the input, decoded against the pairing/frame/PWM state and
// written to the result register. Every input item yields exactly one
// result item. Input stalls only when the result register is full and not
// being taken. Timing registers are written through wr_en/wr_index/wr_data
// and must be set while no item is in flight.
`default_nettype none

module nec_ir_frame_decoder #(
    parameter int PWM_STEPS  = 100,
    parameter int FRAME_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] duration_us
    input  wire logic [1:0]  s_axis_tuser,   // [0] pwm_tick, [1] segment_is_space

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] key_code, [38:32] duty_percent,
                                             // [39] led_on
    output logic [3:0]       m_axis_tuser    // [2:0] symbol, [3] code_valid
);

    localparam int PW = $clog2(PWM_STEPS);
    localparam int BW = $clog2(FRAME_BITS + 1);
    localparam int IW = $clog2(FRAME_BITS);
    localparam logic [PW-1:0] PWM_LAST = PW'(PWM_STEPS - 1);
    localparam logic [BW-1:0] BITS_LAST = BW'(FRAME_BITS - 1);

    // configuration
    necir_pkg::necir_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_mark_us         <= necir_pkg::BIT_MARK_RST;
            cfg_reg.zero_space_us       <= necir_pkg::ZERO_SPACE_RST;
            cfg_reg.one_space_us        <= necir_pkg::ONE_SPACE_RST;
            cfg_reg.header_mark_us      <= necir_pkg::HDR_MARK_RST;
            cfg_reg.header_space_us     <= necir_pkg::HDR_SPACE_RST;
            cfg_reg.bit_tolerance_us    <= necir_pkg::BIT_TOL_RST;
            cfg_reg.header_tolerance_us <= necir_pkg::HDR_TOL_RST;
            cfg_reg.stop_tolerance_us   <= necir_pkg::STOP_TOL_RST;
        end
        else if (wr_en)
        begin
            unique case (necir_pkg::necir_reg_t'(wr_index))
                necir_pkg::REG_BIT_MARK:   cfg_reg.bit_mark_us         <= wr_data;
                necir_pkg::REG_ZERO_SPACE: cfg_reg.zero_space_us       <= wr_data;
                necir_pkg::REG_ONE_SPACE:  cfg_reg.one_space_us        <= wr_data;
                necir_pkg::REG_HDR_MARK:   cfg_reg.header_mark_us      <= wr_data;
                necir_pkg::REG_HDR_SPACE:  cfg_reg.header_space_us     <= wr_data;
                necir_pkg::REG_BIT_TOL:    cfg_reg.bit_tolerance_us    <= wr_data;
                necir_pkg::REG_HDR_TOL:    cfg_reg.header_tolerance_us <= wr_data;
                necir_pkg::REG_STOP_TOL:   cfg_reg.stop_tolerance_us   <= wr_data;
                default: ;
            endcase
        end
    end

    // input register
    logic        in_valid_reg;
    logic        in_tick_reg;
    logic        in_space_reg;
    logic [15:0] in_dur_reg;
    logic        advance;

    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_tick_reg  <= s_axis_tuser[0];
            in_space_reg <= s_axis_tuser[1];
            in_dur_reg   <= s_axis_tdata;
        end
    end

    // decoder state
    logic                  pending_valid_reg, pending_valid_next;
    logic [15:0]           pending_mark_reg, pending_mark_next;
    logic                  frame_active_reg, frame_active_next;
    logic [BW-1:0]         bits_reg, bits_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [6:0]            duty_reg, duty_next;
    logic [PW-1:0]         pwm_reg, pwm_next;
    logic                  led_reg, led_next;

    necir_pkg::necir_sym_t pair_sym;
    necir_pkg::necir_sym_t sym_next;
    logic                  valid_next;
    logic [31:0]           key_next;

    necir_classify u_classify (
        .cfg             (cfg_reg),
        .mark_us         (pending_mark_reg),
        .second_is_space (in_space_reg),
        .second_us       (in_dur_reg),
        .symbol          (pair_sym)
    );

    always_comb
    begin
        pending_valid_next = pending_valid_reg;
        pending_mark_next  = pending_mark_reg;
        frame_active_next  = frame_active_reg;
        bits_next          = bits_reg;
        shift_next         = shift_reg;
        duty_next          = duty_reg;
        pwm_next           = pwm_reg;
        led_next           = led_reg;
        sym_next           = necir_pkg::SYM_NONE;
        valid_next         = 1'b0;
        key_next           = 32'd0;

        if (in_tick_reg)
        begin
            pwm_next = (pwm_reg == PWM_LAST) ? '0 : pwm_reg + 1'b1;
            led_next = 7'(pwm_next) < duty_reg;
        end
        else if (!pending_valid_reg)
        begin
            if (!in_space_reg)
            begin
                pending_valid_next = 1'b1;
                pending_mark_next  = in_dur_reg;
            end
        end
        else
        begin
            sym_next = pair_sym;
            if (pair_sym == necir_pkg::SYM_NONE)
            begin
                // failed pair: a mark becomes the new candidate
                pending_valid_next = !in_space_reg;
                pending_mark_next  = in_space_reg ? 16'd0 : in_dur_reg;
            end
            else
            begin
                pending_valid_next = 1'b0;
                pending_mark_next  = 16'd0;
                if (pair_sym == necir_pkg::SYM_HEADER)
                begin
                    frame_active_next = 1'b1;
                    bits_next         = '0;
                    shift_next        = '0;
                end
                else if (frame_active_reg)
                begin
                    shift_next[bits_reg[IW-1:0]] = pair_sym[0];
                    if (bits_reg == BITS_LAST)
                    begin
                        valid_next        = 1'b1;
                        key_next          = 32'(shift_next);
                        duty_next         = necir_pkg::duty_for(32'(shift_next));
                        frame_active_next = 1'b0;
                        bits_next         = '0;
                    end
                    else
                        bits_next = bits_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_mark_reg  <= 16'd0;
            frame_active_reg  <= 1'b0;
            bits_reg          <= '0;
            shift_reg         <= '0;
            duty_reg          <= 7'd0;
            pwm_reg           <= '0;
            led_reg           <= 1'b0;
        end
        else if (advance)
        begin
            pending_valid_reg <= pending_valid_next;
            pending_mark_reg  <= pending_mark_next;
            frame_active_reg  <= frame_active_next;
            bits_reg          <= bits_next;
            shift_reg         <= shift_next;
            duty_reg          <= duty_next;
            pwm_reg           <= pwm_next;
            led_reg           <= led_next;
        end
    end

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_axis_tdata <= {led_next, duty_next, key_next};
            m_axis_tuser <= {valid_next, sym_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    // checks
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while result path is free");

    a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg < BW'(FRAME_BITS))
        else $error("bit counter past frame length");

    a_code_needs_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tuser[2:0] == necir_pkg::SYM_ZERO ||
             m_axis_tuser[2:0] == necir_pkg::SYM_ONE ||
             m_axis_tuser[2:0] == necir_pkg::SYM_STOP))
        else $error("frame completed without a data symbol");

    a_key_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[3]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("key code set without code_valid");

    a_pending_clear_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_tick_reg && pending_valid_reg &&
         pair_sym != necir_pkg::SYM_NONE) |=> !pending_valid_reg)
        else $error("pending mark kept after a matched pair");

endmodule

`default_nettype wire
